// File: sv/chunked_download_receiver_core_defines.svh
// Assertion macros for the chunked download receiver core.
// Used by chunked_download_receiver_core.sv; expects clk and rst in scope.
`ifndef CHUNKED_DOWNLOAD_RECEIVER_CORE_DEFINES_SVH
`define CHUNKED_DOWNLOAD_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication
`define CDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cdr_pkg.sv
// Package for the chunked download receiver: sizes, codes, payload structs,
// sequencer states and the part length clip. No dependencies.
package cdr_pkg;

  localparam int CHUNKS      = 32;
  localparam int CHUNK_BYTES = 90;
  localparam int PART_BYTES  = CHUNKS * CHUNK_BYTES;

  localparam int LEN_W  = 16;
  localparam int CNT_W  = $clog2(CHUNKS + 1);
  localparam int IDX_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  // reciprocal for rel / CHUNK_BYTES; estimate is floor or floor - 1
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = (1 << RECIP_SHIFT) / CHUNK_BYTES;
  localparam int PROD_W      = LEN_W + RECIP_SHIFT;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_CHUNK   = 2'd1,
    OP_TIMEOUT = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_IGNORED  = 3'd0,
    KIND_ACCEPTED = 3'd1,
    KIND_REQUEST  = 3'd2,
    KIND_PART     = 3'd3,
    KIND_DONE     = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOTAL_BYTES = 1'd0,
    CFG_FILE_ID     = 1'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_FIX,
    S_MARK,
    S_EMIT_IGN,
    S_EMIT_ACC,
    S_SCAN_HIT,
    S_SCAN_MISS,
    S_EMIT_REQ,
    S_EMIT_PART,
    S_EMIT_DONE,
    S_EMIT_OPEN
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] chunk_offset;
    logic [7:0]  chunk_count;
  } item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [LEN_W-1:0] buffer_offset;
    logic [31:0]      request_start;
    logic [LEN_W-1:0] request_count;
    logic [31:0]      bytes_done;
    logic             last_result;
  } result_t;

  function automatic logic [LEN_W-1:0] clip_len(input logic [31:0] left);
    logic [LEN_W-1:0] r;
    if (left < 32'(PART_BYTES)) begin
      r = left[LEN_W-1:0];
    end else begin
      r = LEN_W'(PART_BYTES);
    end
    return r;
  endfunction

endpackage

// File: sv/chunked_download_receiver_core.sv
// Chunked download receiver core: part tracking, chunk bitmap, re-request scan.
// Depends on cdr_pkg and chunked_download_receiver_core_defines.svh.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------
//   item     | item_valid / item_stall| item (item_t)
//   result   | result_valid/result_stall | result (result_t)
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Start and ignored chunk: decode, then the emit step loads the result register. Accepted
// chunk: the divide by CHUNK_BYTES runs as multiply, estimate, correct, then mark and emit.
// Part check scans the bitmap bit by bit to the end of the part or to the first missing
// run, then emits a part result or a re-request for that run.
// Synchronous reset clears control state and the bitmap. A stalled result
// holds the sequencer at its emit step; a new item waits until the last one ends.
`include "chunked_download_receiver_core_defines.svh"

module chunked_download_receiver_core
  import cdr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [31:0]       total_bytes;
  logic              busy;
  logic              rereq;
  logic [31:0]       base;
  logic [LEN_W-1:0]  len;
  logic [CHUNKS-1:0] seen;

  item_t             item_q;
  logic [LEN_W-1:0]  rel;
  logic              do_check;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  q;
  logic [LEN_W-1:0]  qb;
  logic [CNT_W-1:0]  pos;
  logic [LEN_W-1:0]  pb;
  logic [LEN_W-1:0]  start_pb;

  logic              accept;
  logic              emit_en;
  logic              emit_ok;
  result_t           emit_item;
  logic [32:0]       part_end;
  logic [32:0]       item_top;
  logic              ignore;
  logic              done_now;
  logic              scan_live;
  logic              scan_bit;
  logic [LEN_W-1:0]  scan_stop;
  logic [LEN_W-1:0]  rem;
  logic              fix;
  logic [CNT_W-1:0]  q_fin;
  logic [LEN_W-1:0]  qb_fin;
  logic              mark;

  assign accept    = item_valid && !item_stall;
  assign item_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign emit_ok   = !result_valid || !result_stall;

  assign part_end  = {1'b0, base} + 33'(len);
  assign item_top  = {1'b0, item_q.chunk_offset} + 33'(item_q.chunk_count);
  assign ignore    = !busy || (item_q.chunk_count > 8'(CHUNK_BYTES)) ||
                     (item_q.chunk_offset < base) || (item_top > part_end);
  assign done_now  = (part_end >= {1'b0, total_bytes});

  assign scan_live = (pb < len);
  assign scan_bit  = seen[pos[IDX_W-1:0]];
  assign scan_stop = scan_live ? pb : len;

  assign rem    = rel - qb;
  assign fix    = (rem >= LEN_W'(CHUNK_BYTES));
  assign q_fin  = fix ? q + CNT_W'(1) : q;
  assign qb_fin = fix ? qb + LEN_W'(CHUNK_BYTES) : qb;
  assign mark   = (qb_fin < len) && (q_fin < CNT_W'(CHUNKS));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (item_q.opcode)
          OP_START:   state_next = S_EMIT_OPEN;
          OP_CHUNK:   state_next = ignore ? S_EMIT_IGN : S_MUL;
          OP_TIMEOUT: state_next = busy ? S_SCAN_HIT : S_IDLE;
          default:    state_next = S_IDLE;
        endcase
      end
      S_MUL:  state_next = S_FIX;
      S_FIX:  state_next = S_MARK;
      S_MARK: state_next = S_EMIT_ACC;
      S_EMIT_IGN: begin
        if (emit_ok) state_next = S_IDLE;
      end
      S_EMIT_ACC: begin
        if (emit_ok) state_next = do_check ? S_SCAN_HIT : S_IDLE;
      end
      S_SCAN_HIT: begin
        if (!scan_live) begin
          state_next = S_EMIT_PART;
        end else if (!scan_bit) begin
          state_next = S_SCAN_MISS;
        end
      end
      S_SCAN_MISS: begin
        if (!(scan_live && !scan_bit)) state_next = S_EMIT_REQ;
      end
      S_EMIT_REQ: begin
        if (emit_ok) state_next = S_IDLE;
      end
      S_EMIT_PART: begin
        if (emit_ok) state_next = done_now ? S_EMIT_DONE : S_EMIT_OPEN;
      end
      S_EMIT_DONE: begin
        if (emit_ok) state_next = S_IDLE;
      end
      S_EMIT_OPEN: begin
        if (emit_ok) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    emit_en   = 1'b0;
    emit_item = '0;
    unique case (state)
      S_EMIT_IGN: begin
        emit_en               = 1'b1;
        emit_item.kind        = KIND_IGNORED;
        emit_item.last_result = 1'b1;
      end
      S_EMIT_ACC: begin
        emit_en                 = 1'b1;
        emit_item.kind          = KIND_ACCEPTED;
        emit_item.buffer_offset = rel;
        emit_item.last_result   = !do_check;
      end
      S_EMIT_REQ: begin
        emit_en                 = 1'b1;
        emit_item.kind          = KIND_REQUEST;
        emit_item.request_start = base + 32'(start_pb);
        emit_item.request_count = scan_stop - start_pb;
        emit_item.last_result   = 1'b1;
      end
      S_EMIT_PART: begin
        emit_en              = 1'b1;
        emit_item.kind       = KIND_PART;
        emit_item.bytes_done = part_end[31:0];
      end
      S_EMIT_DONE: begin
        emit_en               = 1'b1;
        emit_item.kind        = KIND_DONE;
        emit_item.last_result = 1'b1;
      end
      S_EMIT_OPEN: begin
        emit_en                 = 1'b1;
        emit_item.kind          = KIND_REQUEST;
        emit_item.request_start = base;
        emit_item.request_count = len;
        emit_item.last_result   = 1'b1;
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      total_bytes  <= '0;
      busy         <= 1'b0;
      rereq        <= 1'b0;
      base         <= '0;
      len          <= '0;
      seen         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_e'(cfg_index))
          CFG_TOTAL_BYTES: total_bytes <= cfg_data;
          CFG_FILE_ID: begin
            // identifier is not stored; a write to it has no effect
          end
        endcase
      end
      if (emit_en && emit_ok) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_DECODE: begin
          if (item_q.opcode == OP_START) begin
            busy  <= 1'b1;
            rereq <= 1'b0;
            base  <= '0;
            len   <= clip_len(total_bytes);
            seen  <= '0;
          end else if ((item_q.opcode == OP_TIMEOUT) && busy) begin
            rereq <= 1'b1;
          end
        end
        S_MARK: begin
          if (mark) seen[q_fin[IDX_W-1:0]] <= 1'b1;
        end
        S_EMIT_ACC: begin
          if (emit_ok && do_check) rereq <= 1'b1;
        end
        S_EMIT_PART: begin
          if (emit_ok) begin
            rereq <= 1'b0;
            seen  <= '0;
            if (done_now) begin
              busy <= 1'b0;
              base <= '0;
              len  <= '0;
            end else begin
              base <= part_end[31:0];
              len  <= clip_len(total_bytes - part_end[31:0]);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_q <= item;
    if (emit_en && emit_ok) result <= emit_item;
    if (state == S_DECODE) begin
      rel      <= LEN_W'(item_q.chunk_offset - base);
      do_check <= (item_top == part_end) || rereq;
    end
    if (state == S_MUL) prod <= PROD_W'(rel) * PROD_W'(RECIP);
    if (state == S_FIX) begin
      q  <= prod[RECIP_SHIFT +: CNT_W];
      qb <= LEN_W'(prod[RECIP_SHIFT +: CNT_W]) * LEN_W'(CHUNK_BYTES);
    end
    if ((state_next == S_SCAN_HIT) && (state != S_SCAN_HIT)) begin
      pos <= '0;
      pb  <= '0;
    end else if (((state == S_SCAN_HIT) || (state == S_SCAN_MISS)) && scan_live &&
                 (scan_bit == (state == S_SCAN_HIT))) begin
      pos <= pos + CNT_W'(1);
      pb  <= pb + LEN_W'(CHUNK_BYTES);
    end
    if ((state == S_SCAN_HIT) && scan_live && !scan_bit) start_pb <= pb;
  end

  `CDR_ASSERT_NOW(a_scan_in_map, ((state == S_SCAN_HIT) || (state == S_SCAN_MISS)) && scan_live, pos < CNT_W'(CHUNKS), "bitmap scan index beyond chunk count")
  `CDR_ASSERT_NOW(a_req_in_part, result_valid && (result.kind == KIND_REQUEST), result.request_count <= LEN_W'(PART_BYTES), "request longer than a part")
  `CDR_ASSERT_NOW(a_done_clears, state == S_EMIT_DONE, !busy && (seen == '0) && (len == '0), "download complete with live part state")
  `CDR_ASSERT_NEXT(a_part_follow, (state == S_EMIT_PART) && emit_ok, (state == S_EMIT_DONE) || (state == S_EMIT_OPEN), "part complete not followed by finish or next request")

endmodule
